@@ hdl/pbd_pkg.sv @@
`default_nettype none

package pbd_pkg;

  // Opcode table entry: operand kind + 1, zero for unknown, eleven for the
  // extended-argument prefix.
  localparam logic [3:0] TE_UNKNOWN  = 4'd0;
  localparam logic [3:0] TE_SIMPLE   = 4'd1;
  localparam logic [3:0] TE_NUMBER   = 4'd2;
  localparam logic [3:0] TE_NAME     = 4'd3;
  localparam logic [3:0] TE_JUMP_REL = 4'd4;
  localparam logic [3:0] TE_JUMP_ABS = 4'd5;
  localparam logic [3:0] TE_UNPACK   = 4'd6;
  localparam logic [3:0] TE_CALL     = 4'd7;
  localparam logic [3:0] TE_FUNCTION = 4'd8;
  localparam logic [3:0] TE_CONST    = 4'd9;
  localparam logic [3:0] TE_COMPARE  = 4'd10;
  localparam logic [3:0] TE_EXT_ARG  = 4'd11;

  localparam logic [3:0] KIND_SIMPLE = 4'd0;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_FORMAT = 1'b0;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       object_start;
    logic       object_end;
  } pbd_item_t;

  typedef struct packed {
    logic [31:0] start_offset;
    logic [7:0]  opcode_value;
    logic [3:0]  operand_kind;
    logic [31:0] argument;
    logic        has_argument;
    logic [1:0]  status;
  } pbd_result_t;

  function automatic logic [3:0] pbd_lookup(input logic wordcode, input logic [7:0] op);
    logic [3:0] ent;
    unique case (op) inside
      [8'd1:8'd5], [8'd9:8'd12], [8'd15:8'd17], 8'd19, 8'd20, [8'd22:8'd29],
      [8'd50:8'd52], [8'd54:8'd57], [8'd59:8'd73], [8'd75:8'd89]:
        ent = TE_SIMPLE;
      8'd90, 8'd91, [8'd95:8'd98], 8'd101, 8'd106, 8'd108, 8'd109, 8'd116:
        ent = TE_NAME;
      8'd92, [8'd102:8'd105], [8'd124:8'd127], 8'd130, 8'd133, [8'd135:8'd138],
      [8'd145:8'd153], [8'd155:8'd158]:
        ent = TE_NUMBER;
      8'd93, 8'd110, [8'd120:8'd122], 8'd143, 8'd154:
        ent = TE_JUMP_REL;
      [8'd111:8'd115], 8'd119:
        ent = TE_JUMP_ABS;
      8'd94:         ent = TE_UNPACK;
      8'd100:        ent = TE_CONST;
      8'd107:        ent = TE_COMPARE;
      8'd131, 8'd140, 8'd141:
        ent = TE_CALL;
      8'd132, 8'd134:
        ent = TE_FUNCTION;
      8'd142:        ent = wordcode ? TE_NUMBER : TE_CALL;
      8'd144:        ent = TE_EXT_ARG;
      default:       ent = TE_UNKNOWN;
    endcase
    return ent;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pbd_if.sv @@
`default_nettype none

interface pbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       object_start;
  logic       object_end;

  modport source(output valid, output code_byte, output object_start,
                 output object_end, input ready);
  modport sink(input valid, input code_byte, input object_start,
               input object_end, output ready);
endinterface

interface pbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_offset;
  logic [7:0]  opcode_value;
  logic [3:0]  operand_kind;
  logic [31:0] argument;
  logic        has_argument;
  logic [1:0]  status;

  modport source(output valid, output start_offset, output opcode_value,
                 output operand_kind, output argument, output has_argument,
                 output status, input ready);
  modport sink(input valid, input start_offset, input opcode_value,
               input operand_kind, input argument, input has_argument,
               input status, output ready);
endinterface

`default_nettype wire

@@ hdl/pbd_in_reg.sv @@
`default_nettype none

module pbd_in_reg
  import pbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pbd_in_if.sink     in_bus,
  input  wire logic  advance,
  output pbd_item_t  item,
  output logic       item_valid
);

  logic      valid_r, valid_nxt;
  pbd_item_t item_r;
  logic      take;

  assign in_bus.ready = !valid_r || advance;
  assign take         = in_bus.valid && in_bus.ready;
  assign valid_nxt    = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.code_byte    <= in_bus.code_byte;
      item_r.object_start <= in_bus.object_start;
      item_r.object_end   <= in_bus.object_end;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

@@ hdl/pbd_core.sv @@
`default_nettype none

module pbd_core
  import pbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wordcode,
  input  wire logic       advance,
  input  wire pbd_item_t  item,
  output logic            res_emit,
  output pbd_result_t     res
);

  typedef enum logic [1:0] {
    PH_OPCODE     = 2'd0,
    PH_ARG_LO     = 2'd1,
    PH_ARG_HI     = 2'd2,
    PH_EXT_OPCODE = 2'd3
  } phase_t;

  logic [31:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] start_r, start_nxt;
  logic        halt_r, halt_nxt;

  logic [31:0] cur_pos;
  logic [3:0]  ent_b, ent_op, ent_last;
  logic        do_finish, took_opcode, emit;
  logic [3:0]  kind;
  logic [31:0] arg;
  logic [1:0]  status;

  assign ent_b  = pbd_lookup(wordcode, item.code_byte);
  assign ent_op = pbd_lookup(wordcode, op_r);

  always_comb begin
    cur_pos     = item.object_start ? 32'd0 : pos_r;
    phase_nxt   = item.object_start ? PH_OPCODE : phase_r;
    op_nxt      = item.object_start ? 8'd0 : op_r;
    acc_nxt     = item.object_start ? 32'd0 : acc_r;
    seen_nxt    = item.object_start ? 1'b0 : seen_r;
    start_nxt   = item.object_start ? 32'd0 : start_r;
    halt_nxt    = item.object_start ? 1'b0 : halt_r;
    do_finish   = 1'b0;
    took_opcode = 1'b0;
    emit        = 1'b0;
    kind        = KIND_SIMPLE;
    arg         = 32'd0;
    status      = ST_OK;
    ent_last    = ent_op;

    if (!halt_nxt) begin
      unique case (phase_nxt)
        PH_OPCODE, PH_EXT_OPCODE: begin
          if (phase_nxt == PH_OPCODE) begin
            start_nxt = cur_pos;
            acc_nxt   = 32'd0;
            seen_nxt  = 1'b0;
          end
          op_nxt      = item.code_byte;
          took_opcode = 1'b1;
          if (ent_b == TE_UNKNOWN) begin
            emit      = 1'b1;
            arg       = acc_nxt;
            status    = ST_UNKNOWN;
            halt_nxt  = 1'b1;
            phase_nxt = PH_OPCODE;
          end else if (wordcode || ent_b != TE_SIMPLE) begin
            phase_nxt = PH_ARG_LO;
          end else begin
            phase_nxt = PH_OPCODE;
            emit      = 1'b1;
            arg       = acc_nxt;
          end
        end
        PH_ARG_LO: begin
          seen_nxt = 1'b1;
          if (wordcode) begin
            acc_nxt   = {acc_nxt[23:0], item.code_byte};
            do_finish = 1'b1;
          end else begin
            acc_nxt   = {acc_nxt[15:0], 8'h00, item.code_byte};
            phase_nxt = PH_ARG_HI;
          end
        end
        PH_ARG_HI: begin
          acc_nxt   = acc_nxt | {16'h0000, item.code_byte, 8'h00};
          do_finish = 1'b1;
        end
        default: begin
          phase_nxt = PH_OPCODE;
        end
      endcase
    end

    // argument complete: another prefix, or a finished instruction
    if (do_finish) begin
      if (ent_op == TE_EXT_ARG) begin
        phase_nxt = PH_EXT_OPCODE;
      end else begin
        phase_nxt = PH_OPCODE;
        emit      = 1'b1;
        kind      = ent_op - 4'd1;
        arg       = (ent_op == TE_JUMP_REL) ? acc_nxt + cur_pos + 32'd1 : acc_nxt;
      end
    end

    if (took_opcode) begin
      ent_last = ent_b;
    end

    // object ends mid-instruction
    if (item.object_end && !emit && !halt_nxt && phase_nxt != PH_OPCODE) begin
      emit   = 1'b1;
      kind   = (ent_last == TE_EXT_ARG || ent_last == TE_UNKNOWN) ? KIND_SIMPLE
                                                                  : ent_last - 4'd1;
      arg    = acc_nxt;
      status = ST_TRUNC;
    end

    res.start_offset = start_nxt;
    res.opcode_value = op_nxt;
    res.operand_kind = kind;
    res.argument     = arg;
    res.has_argument = seen_nxt;
    res.status       = status;
    res_emit         = emit;

    pos_nxt = cur_pos + 32'd1;
    if (item.object_end) begin
      pos_nxt   = 32'd0;
      phase_nxt = PH_OPCODE;
      op_nxt    = 8'd0;
      acc_nxt   = 32'd0;
      seen_nxt  = 1'b0;
      start_nxt = 32'd0;
      halt_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 32'd0;
      phase_r <= PH_OPCODE;
      op_r    <= 8'd0;
      acc_r   <= 32'd0;
      seen_r  <= 1'b0;
      start_r <= 32'd0;
      halt_r  <= 1'b0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      start_r <= start_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pbd_out_reg.sv @@
`default_nettype none

module pbd_out_reg
  import pbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire pbd_result_t res,
  output logic             busy,
  pbd_out_if.source        out_bus
);

  logic        valid_r, valid_nxt;
  pbd_result_t res_r;

  // load only comes when the register is empty or being drained
  assign valid_nxt = load ? 1'b1 : (out_bus.ready ? 1'b0 : valid_r);
  assign busy      = valid_r && !out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid        = valid_r;
  assign out_bus.start_offset = res_r.start_offset;
  assign out_bus.opcode_value = res_r.opcode_value;
  assign out_bus.operand_kind = res_r.operand_kind;
  assign out_bus.argument     = res_r.argument;
  assign out_bus.has_argument = res_r.has_argument;
  assign out_bus.status       = res_r.status;

endmodule

`default_nettype wire

@@ hdl/python_bytecode_decoder_unit.sv @@
// Path: a byte accepted into the input register goes through decode, and its result
//   (if any) is held in the result register that drives the result channel.
// Throughput: one byte per cycle; the only stall comes from the result channel.
// Reset (rst_n low at a clock edge, synchronous): decode state goes to the start of
//   an object, both channels empty, the format register returns to the older format.
`default_nettype none

module python_bytecode_decoder_unit
  import pbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  pbd_in_if.sink           in_bus,
  pbd_out_if.source        out_bus,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration: one register, the bytecode format select, at byte address 0.
  // paddr[2] picks the register index; low address bits are ignored.
  // ---------------------------------------------------------------------------
  logic fmt_r, fmt_nxt;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign fmt_nxt    = (cfg_wr && cfg_paddr[2] == CFG_IDX_FORMAT) ? cfg_pwdata[0] : fmt_r;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_FORMAT) ? {31'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: input register -> decode (table lookup, argument build, jump
  // fixup) -> result register. The staged request moves on whenever the result
  // register is empty or being drained, whether or not it yields a result, so
  // a new byte can enter every cycle.
  // ---------------------------------------------------------------------------
  pbd_item_t   item;
  logic        item_valid;
  logic        advance;
  logic        res_emit;
  pbd_result_t res;
  logic        out_busy;

  assign advance = item_valid && !out_busy;

  pbd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  // decode state only moves when the staged byte is consumed
  pbd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .wordcode (fmt_r),
    .advance  (advance),
    .item     (item),
    .res_emit (res_emit),
    .res      (res)
  );

  pbd_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance && res_emit),
    .res     (res),
    .busy    (out_busy),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

@@ hdl/pbd_checker.sv @@
`default_nettype none

module pbd_checker
  import pbd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  operand_kind,
  input wire logic [31:0] argument,
  input wire logic        has_argument,
  input wire logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_UNKNOWN || status == ST_TRUNC))
    else $error("bad status code");

  a_unknown_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_UNKNOWN |-> operand_kind == KIND_SIMPLE)
    else $error("unknown opcode with nonzero kind");

  a_no_arg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_argument |-> argument == 32'd0)
    else $error("argument without argument bytes");

endmodule

bind python_bytecode_decoder_unit pbd_checker u_pbd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .operand_kind (out_bus.operand_kind),
  .argument     (out_bus.argument),
  .has_argument (out_bus.has_argument),
  .status       (out_bus.status)
);

`default_nettype wire
